FILE: rtl/tlfq_pkg.sv
// shared types, constants and helpers for the three-level feedback queue scheduler
package tlfq_pkg;

    localparam int LEVEL_DEPTH = 16;
    localparam int LEVELS      = 3;
    localparam int PTR_W       = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int LEN_W       = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W      = $clog2(LEVELS * LEVEL_DEPTH);
    localparam int RAM_DEPTH   = LEVELS * LEVEL_DEPTH;
    localparam int SUM_NEED    = $clog2(LEVELS * LEVEL_DEPTH * 65535 + 1);
    localparam int SUM_W       = (SUM_NEED > 22) ? SUM_NEED : 22;
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(4194303);

    localparam logic [0:0] OP_INSERT = 1'b0;
    localparam logic [0:0] OP_TICK   = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_BAD_PRIO = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_SERVED   = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [7:0] DEMOTE_RESET = 8'd2;
    localparam logic [7:0] USES_MAX     = 8'd255;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] left;
        logic [1:0]  prio;
        logic [7:0]  uses;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] served_id;
        logic [15:0] served_left;
        logic [1:0]  served_priority;
        logic [7:0]  served_count;
        logic [1:0]  served_level;
        logic [1:0]  moved_to;
    } t_result;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] nxt;
        nxt = {1'b0, p} + (PTR_W+1)'(1);
        return (nxt >= (PTR_W+1)'(LEVEL_DEPTH)) ? '0 : nxt[PTR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] lv,
                                                    input logic [PTR_W-1:0] p);
        return ADDR_W'(32'(lv) * LEVEL_DEPTH) + ADDR_W'(p);
    endfunction

endpackage

FILE: rtl/tlfq_in_if.sv
// input channel: insert or tick request beats
interface tlfq_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  opcode;
    logic [15:0] new_id;
    logic [15:0] new_time;
    logic [1:0]  new_priority;

    modport source (output valid, opcode, new_id, new_time, new_priority, input ready);
    modport sink   (input valid, opcode, new_id, new_time, new_priority, output ready);
endinterface

FILE: rtl/tlfq_out_if.sv
// output channel: one result beat per request
interface tlfq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] served_id;
    logic [15:0] served_left;
    logic [1:0]  served_priority;
    logic [7:0]  served_count;
    logic [1:0]  served_level;
    logic [1:0]  moved_to;
    logic [4:0]  level1_length;
    logic [4:0]  level2_length;
    logic [4:0]  level3_length;
    logic [21:0] total_left;

    modport source (output valid, status, served_id, served_left, served_priority,
                    served_count, served_level, moved_to, level1_length,
                    level2_length, level3_length, total_left, input ready);
    modport sink   (input valid, status, served_id, served_left, served_priority,
                    served_count, served_level, moved_to, level1_length,
                    level2_length, level3_length, total_left, output ready);
endinterface

FILE: rtl/three_level_feedback_queue_scheduler_unit.sv
// top level of the three-level feedback queue scheduler
// usage:
//   i_in carries requests: opcode insert (id, time, priority) or tick.
//   o_out carries exactly one result beat per request, in request order:
//   status, the served entry after a tick, the three level lengths and the
//   total remaining time after the step.
//   i_cfg_we / i_cfg_data write the demotion limit; write only while idle.
// sequence:
//   a request is accepted in the idle state, where the entry ram reads the
//   head entry of the highest non-empty level; in the exec state, a tick
//   writes the updated entry back at a tail unless its time is used up, an
//   insert with a legal priority and room writes its entry at a tail, and
//   the result register is loaded; only then is a new request taken.
// reset:
//   synchronous active-low i_rst_n empties all levels, clears the sum and
//   sets the demotion limit to 2; the entry ram itself is not cleared.
// stall:
//   a held result stays in the output register; the next request is still
//   accepted, but its completion waits until the pending beat is taken.
module three_level_feedback_queue_scheduler_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlfq_in_if.sink           i_in,
    tlfq_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [tlfq_pkg::PTR_W-1:0] r_head [tlfq_pkg::LEVELS];
    logic [tlfq_pkg::PTR_W-1:0] n_head [tlfq_pkg::LEVELS];
    logic [tlfq_pkg::PTR_W-1:0] r_tail [tlfq_pkg::LEVELS];
    logic [tlfq_pkg::PTR_W-1:0] n_tail [tlfq_pkg::LEVELS];
    logic [tlfq_pkg::LEN_W-1:0] r_len  [tlfq_pkg::LEVELS];
    logic [tlfq_pkg::LEN_W-1:0] n_len  [tlfq_pkg::LEVELS];
    logic [tlfq_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [7:0]                 r_demote;

    logic [0:0]  r_op;
    logic [15:0] r_id;
    logic [15:0] r_time;
    logic [1:0]  r_prio;
    logic [1:0]  r_lv;
    logic        r_none;

    tlfq_pkg::t_result r_res, n_res;
    logic              r_ovalid;

    logic                        in_acc;
    logic                        out_free;
    logic                        exec_go;
    logic [1:0]                  sel_lv;
    logic                        sel_none;
    logic                        wr_en;
    logic [tlfq_pkg::ADDR_W-1:0] wr_addr;
    tlfq_pkg::t_entry            wr_entry;
    logic [tlfq_pkg::ENTRY_W-1:0] rd_data;
    tlfq_pkg::t_entry            e_rd;
    tlfq_pkg::t_entry            e_new;
    logic [1:0]                  tl;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign exec_go  = (r_state == S_EXEC) && out_free;
    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        sel_none = 1'b0;
        if (r_len[0] != '0) begin
            sel_lv = 2'd0;
        end else if (r_len[1] != '0) begin
            sel_lv = 2'd1;
        end else begin
            sel_lv = 2'd2;
            sel_none = (r_len[2] == '0);
        end
    end

    tlfq_ram #(
        .WIDTH (tlfq_pkg::ENTRY_W),
        .DEPTH (tlfq_pkg::RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_re    (in_acc),
        .i_raddr (tlfq_pkg::slot_addr(sel_lv, r_head[sel_lv])),
        .o_rdata (rd_data)
    );

    assign e_rd = tlfq_pkg::t_entry'(rd_data);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_len    = r_len;
        n_sum    = r_sum;
        n_res    = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_entry = '0;
        e_new    = e_rd;
        tl       = 2'd0;
        if (r_op == tlfq_pkg::OP_INSERT) begin
            if (r_prio == 2'd0) begin
                n_res.status = tlfq_pkg::ST_BAD_PRIO;
            end else begin
                tl = r_prio - 2'd1;
                if (r_len[tl] >= tlfq_pkg::LEN_W'(tlfq_pkg::LEVEL_DEPTH)) begin
                    n_res.status = tlfq_pkg::ST_FULL;
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = tlfq_pkg::slot_addr(tl, r_tail[tl]);
                    wr_entry     = '{id: r_id, left: r_time, prio: r_prio, uses: 8'd0};
                    n_tail[tl]   = tlfq_pkg::ptr_adv(r_tail[tl]);
                    n_len[tl]    = r_len[tl] + tlfq_pkg::LEN_W'(1);
                    n_sum        = r_sum + tlfq_pkg::SUM_W'(r_time);
                    n_res.status = tlfq_pkg::ST_INSERTED;
                end
            end
        end else if (r_none) begin
            n_res.status = tlfq_pkg::ST_EMPTY;
        end else begin
            n_head[r_lv] = tlfq_pkg::ptr_adv(r_head[r_lv]);
            n_len[r_lv]  = r_len[r_lv] - tlfq_pkg::LEN_W'(1);
            if (e_rd.uses != tlfq_pkg::USES_MAX) begin
                e_new.uses = e_rd.uses + 8'd1;
            end
            if (e_rd.left != 16'd0) begin
                e_new.left = e_rd.left - 16'd1;
                n_sum      = r_sum - tlfq_pkg::SUM_W'(1);
            end
            tl = r_lv;
            if (e_new.left == 16'd0) begin
                n_res.moved_to = 2'd0;
            end else begin
                if (r_lv != 2'd2 && e_new.uses >= r_demote) begin
                    if (r_len[r_lv + 2'd1] < tlfq_pkg::LEN_W'(tlfq_pkg::LEVEL_DEPTH)) begin
                        tl         = r_lv + 2'd1;
                        e_new.uses = 8'd0;
                    end
                end
                wr_en          = 1'b1;
                wr_addr        = tlfq_pkg::slot_addr(tl, r_tail[tl]);
                wr_entry       = e_new;
                n_tail[tl]     = tlfq_pkg::ptr_adv(r_tail[tl]);
                n_len[tl]      = n_len[tl] + tlfq_pkg::LEN_W'(1);
                n_res.moved_to = tl + 2'd1;
            end
            n_res.status          = tlfq_pkg::ST_SERVED;
            n_res.served_id       = e_new.id;
            n_res.served_left     = e_new.left;
            n_res.served_priority = e_new.prio;
            n_res.served_count    = e_new.uses;
            n_res.served_level    = r_lv + 2'd1;
        end
        if (!exec_go) begin
            wr_en = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sum    <= '0;
            r_demote <= tlfq_pkg::DEMOTE_RESET;
            for (int l = 0; l < tlfq_pkg::LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_len[l]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_demote <= i_cfg_data;
            end
            if (exec_go) begin
                r_ovalid <= 1'b1;
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_len    <= n_len;
                r_sum    <= n_sum;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_in.opcode;
            r_id   <= i_in.new_id;
            r_time <= i_in.new_time;
            r_prio <= i_in.new_priority;
            r_lv   <= sel_lv;
            r_none <= sel_none;
        end
        if (exec_go) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.status          = r_res.status;
    assign o_out.served_id       = r_res.served_id;
    assign o_out.served_left     = r_res.served_left;
    assign o_out.served_priority = r_res.served_priority;
    assign o_out.served_count    = r_res.served_count;
    assign o_out.served_level    = r_res.served_level;
    assign o_out.moved_to        = r_res.moved_to;
    assign o_out.level1_length   = 5'(r_len[0]);
    assign o_out.level2_length   = 5'(r_len[1]);
    assign o_out.level3_length   = 5'(r_len[2]);
    assign o_out.total_left      = (r_sum > tlfq_pkg::SUM_MAX) ? 22'(tlfq_pkg::SUM_MAX)
                                                               : 22'(r_sum);

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len[0] <= tlfq_pkg::LEN_W'(tlfq_pkg::LEVEL_DEPTH) &&
        r_len[1] <= tlfq_pkg::LEN_W'(tlfq_pkg::LEVEL_DEPTH) &&
        r_len[2] <= tlfq_pkg::LEN_W'(tlfq_pkg::LEVEL_DEPTH))
        else $error("level length above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len[0] != '0 || r_head[0] == r_tail[0]) &&
        (r_len[1] != '0 || r_head[1] == r_tail[1]) &&
        (r_len[2] != '0 || r_head[2] == r_tail[2]))
        else $error("empty level with head and tail apart");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_go |=> r_ovalid && r_state == S_IDLE)
        else $error("completed request without a result beat");

    a_served_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.status == tlfq_pkg::ST_SERVED |-> r_res.served_level != 2'd0)
        else $error("served result without a level");
`endif

endmodule

FILE: rtl/tlfq_ram.sv
// generic single-write, single-read ram with registered read data
module tlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
